// ----- rtl/gsgc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsgc_pkg
// Shared types, constants and helpers of the greedy graph clustering block.
// ----------------------------------------------------------------------------
package gsgc_pkg;

	// Membership store geometry
	localparam int MAX_VERTICES = 4096;
	localparam int AW           = $clog2(MAX_VERTICES);

	// Field widths
	localparam int VID_W   = 12;
	localparam int WGT_W   = 16;
	localparam int CLS_W   = 12;
	localparam int CNT_W   = 13;
	localparam int THR_W   = 17;
	localparam int CFG_W   = 17;
	localparam int MEM_W   = CLS_W + 1;

	// Saturation limits
	localparam logic [CNT_W-1:0] CNT_MAX   = '1;
	localparam logic [CLS_W-1:0] CLASS_MAX = '1;

	// Reset values of the configuration registers
	localparam logic [WGT_W-1:0] SNODE_MIN_RST = 16'd5;
	localparam logic [THR_W-1:0] GLUE_THR_RST  = 17'd32768;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_SNODE_MIN = 1'b0,
		REG_GLUE_THR  = 1'b1
	} cfg_reg_t;

	// Word held per vertex in the membership store
	typedef struct packed {
		logic             assigned;
		logic [CLS_W-1:0] cls;
	} mem_word_t;

	// One neighbor entry with its membership lookup
	typedef struct packed {
		logic [VID_W-1:0] vid;
		logic [WGT_W-1:0] weight;
		logic [VID_W-1:0] nid;
		logic             present;
		logic             last;
		mem_word_t        mem;
	} entry_t;

	// Placement write issued by the back end
	typedef struct packed {
		logic             en;
		logic [VID_W-1:0] addr;
		logic [CLS_W-1:0] cls;
	} place_wr_t;

	// Write port of the membership RAM
	typedef struct packed {
		logic          en;
		logic [AW-1:0] addr;
		mem_word_t     data;
	} ram_wr_t;

	// Bring a queued entry up to date with a placement made after its lookup
	function automatic entry_t patch_entry(entry_t e, place_wr_t wr);
		entry_t r;
		r = e;
		if (wr.en && (wr.addr == e.nid)) begin
			r.mem.assigned = 1'b1;
			r.mem.cls      = wr.cls;
		end
		return r;
	endfunction

endpackage

// ----- rtl/greedy_sequential_graph_clustering_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_sequential_graph_clustering_top
// Places vertices into classes from a stream of neighbor entries.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 4096-entry membership store clean, one
// entry a cycle, and holds in_ready low until the sweep is done; configuration
// writes are taken throughout. From then on it takes one neighbor entry per
// cycle while the queue has space: the front end issues one membership RAM
// read per entry, the entry waits in a two-entry queue, and the back end
// counts and decides on one entry per cycle. A result passes the lookup stage
// and the queue and sits in an output register so that intake goes on while
// it waits to be taken; only a blocked result stalls the back end.
module greedy_sequential_graph_clustering_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [gsgc_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [gsgc_pkg::VID_W-1:0]  vertex_id,
	input  logic [gsgc_pkg::WGT_W-1:0]  vertex_weight,
	input  logic [gsgc_pkg::VID_W-1:0]  neighbor_id,
	input  logic                        neighbor_present,
	input  logic                        last_entry,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [gsgc_pkg::VID_W-1:0]  placed_vertex,
	output logic [gsgc_pkg::CLS_W-1:0]  class_id,
	output logic                        opened_class,
	output logic                        class_has_supernode
);

	import gsgc_pkg::*;

	place_wr_t     place_wr;
	ram_wr_t       ram_wr;
	mem_word_t     ram_rdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic          q_space;
	logic          q_push;
	entry_t        q_entry;
	logic          q_pop;
	logic          head_valid;
	entry_t        head;

	// Membership store
	gsgc_ram #(
		.WIDTH (MEM_W),
		.DEPTH (MAX_VERTICES)
	) u_ram (
		.clk   (clk),
		.we    (ram_wr.en),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Intake and lookup
	gsgc_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.vertex_id        (vertex_id),
		.vertex_weight    (vertex_weight),
		.neighbor_id      (neighbor_id),
		.neighbor_present (neighbor_present),
		.last_entry       (last_entry),
		.place_wr         (place_wr),
		.ram_rdata        (ram_rdata),
		.ram_re           (ram_re),
		.ram_raddr        (ram_raddr),
		.ram_wr           (ram_wr),
		.q_space          (q_space),
		.q_push           (q_push),
		.q_entry          (q_entry)
	);

	// Decoupling queue
	gsgc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.space      (q_space),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head       (head),
		.place_wr   (place_wr)
	);

	// Counting and decision
	gsgc_back u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_wdata           (cfg_wdata),
		.head_valid          (head_valid),
		.head                (head),
		.pop                 (q_pop),
		.place_wr            (place_wr),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.placed_vertex       (placed_vertex),
		.class_id            (class_id),
		.opened_class        (opened_class),
		.class_has_supernode (class_has_supernode)
	);

endmodule

// ----- rtl/gsgc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsgc_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module gsgc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, old data on collision, output held while not reading
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/gsgc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsgc_front
// Accepts neighbor entries, looks up neighbor membership, clears the store.
// ----------------------------------------------------------------------------
module gsgc_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [gsgc_pkg::VID_W-1:0] vertex_id,
	input  logic [gsgc_pkg::WGT_W-1:0] vertex_weight,
	input  logic [gsgc_pkg::VID_W-1:0] neighbor_id,
	input  logic                      neighbor_present,
	input  logic                      last_entry,
	input  gsgc_pkg::place_wr_t       place_wr,
	input  gsgc_pkg::mem_word_t       ram_rdata,
	output logic                      ram_re,
	output logic [gsgc_pkg::AW-1:0]   ram_raddr,
	output gsgc_pkg::ram_wr_t         ram_wr,
	input  logic                      q_space,
	output logic                      q_push,
	output gsgc_pkg::entry_t          q_entry
);

	import gsgc_pkg::*;

	logic                 clearing_q;
	logic [AW-1:0]        clr_addr_q;
	logic                 s1_valid_q;
	entry_t               s1_entry_s1;
	logic                 s1_fwd_s1;
	logic [CLS_W-1:0]     s1_fwd_cls_s1;
	logic                 accept;
	logic                 in_hit;
	logic                 s1_hit;
	entry_t               lookup;

	// Clearing pass over the membership store after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(MAX_VERTICES - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// RAM write port: clear sweep, then placements
	always_comb begin
		if (clearing_q) begin
			ram_wr.en            = 1'b1;
			ram_wr.addr          = clr_addr_q;
			ram_wr.data.assigned = 1'b0;
			ram_wr.data.cls      = '0;
		end else begin
			ram_wr.en   = place_wr.en;
			ram_wr.addr = AW'(place_wr.addr);
			ram_wr.data.assigned = 1'b1;
			ram_wr.data.cls      = place_wr.cls;
		end
	end

	// Handshake
	assign q_push   = s1_valid_q && q_space;
	assign in_ready = !clearing_q && (!s1_valid_q || q_push);
	assign accept   = in_valid && in_ready;

	assign ram_re    = accept;
	assign ram_raddr = AW'(neighbor_id);

	// Placements landing after the lookup was issued
	assign in_hit = place_wr.en && (place_wr.addr == neighbor_id);
	assign s1_hit = place_wr.en && (place_wr.addr == s1_entry_s1.nid);

	// Lookup stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (q_push) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Lookup stage payload and forwarding
	always_ff @(posedge clk) begin
		if (accept) begin
			s1_entry_s1.vid     <= vertex_id;
			s1_entry_s1.weight  <= vertex_weight;
			s1_entry_s1.nid     <= neighbor_id;
			s1_entry_s1.present <= neighbor_present;
			s1_entry_s1.last    <= last_entry;
			s1_entry_s1.mem     <= '0;
			s1_fwd_s1           <= in_hit;
			s1_fwd_cls_s1       <= place_wr.cls;
		end else if (s1_hit) begin
			s1_fwd_s1     <= 1'b1;
			s1_fwd_cls_s1 <= place_wr.cls;
		end
	end

	// Merge RAM data with forwarded placements
	always_comb begin
		lookup = s1_entry_s1;
		if (s1_fwd_s1) begin
			lookup.mem.assigned = 1'b1;
			lookup.mem.cls      = s1_fwd_cls_s1;
		end else begin
			lookup.mem = ram_rdata;
		end
		q_entry = patch_entry(lookup, place_wr);
	end

endmodule

// ----- rtl/gsgc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsgc_queue
// Two-entry queue between front and back; keeps lookups current on placement.
// ----------------------------------------------------------------------------
module gsgc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  gsgc_pkg::entry_t    push_entry,
	output logic                space,
	input  logic                pop,
	output logic                head_valid,
	output gsgc_pkg::entry_t    head,
	input  gsgc_pkg::place_wr_t place_wr
);

	import gsgc_pkg::*;

	logic [1:0] count_q;
	entry_t     slot0_q;
	entry_t     slot1_q;
	entry_t     slot0_p;
	entry_t     slot1_p;
	entry_t     slot0_d;
	entry_t     slot1_d;

	assign head_valid = (count_q != 2'd0);
	assign head       = slot0_q;
	assign space      = (count_q != 2'd2) || pop;

	assign slot0_p = patch_entry(slot0_q, place_wr);
	assign slot1_p = patch_entry(slot1_q, place_wr);

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (push && !pop) begin
			count_q <= count_q + 2'd1;
		end else if (pop && !push) begin
			count_q <= count_q - 2'd1;
		end
	end

	// Next slot contents; slots shift toward the head
	always_comb begin
		slot0_d = slot0_p;
		slot1_d = slot1_p;
		case (count_q)
			2'd0: begin
				if (push) begin
					slot0_d = push_entry;
				end
			end
			2'd1: begin
				if (push && pop) begin
					slot0_d = push_entry;
				end else if (push) begin
					slot1_d = push_entry;
				end
			end
			2'd2: begin
				if (pop) begin
					slot0_d = slot1_p;
					if (push) begin
						slot1_d = push_entry;
					end
				end
			end
			default: begin
				slot0_d = slot0_p;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		slot0_q <= slot0_d;
		slot1_q <= slot1_d;
	end

endmodule

// ----- rtl/gsgc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsgc_back
// Counts in-class neighbors, decides placement and holds the result register.
// ----------------------------------------------------------------------------
module gsgc_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [gsgc_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic                        head_valid,
	input  gsgc_pkg::entry_t            head,
	output logic                        pop,
	output gsgc_pkg::place_wr_t         place_wr,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [gsgc_pkg::VID_W-1:0]  placed_vertex,
	output logic [gsgc_pkg::CLS_W-1:0]  class_id,
	output logic                        opened_class,
	output logic                        class_has_supernode
);

	import gsgc_pkg::*;

	logic [WGT_W-1:0] snode_min_q;
	logic [THR_W-1:0] glue_thr_q;
	logic [CLS_W-1:0] cur_class_q;
	logic [CNT_W-1:0] cur_size_q;
	logic             cur_super_q;
	logic [CNT_W-1:0] hits_q;
	logic             first_q;
	logic             out_valid_q;
	logic [VID_W-1:0] placed_q;
	logic [CLS_W-1:0] class_q;
	logic             opened_q;
	logic             super_q;

	logic             nid_in_range;
	logic             vid_in_range;
	logic             hit;
	logic [CNT_W-1:0] hits_eff;
	logic             snode;
	logic [CLS_W-1:0] cls_inc;
	logic [29:0]      lhs;
	logic [29:0]      rhs;
	logic             glue;
	logic [CLS_W-1:0] cls;
	logic             super_after;
	logic             decide;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snode_min_q <= SNODE_MIN_RST;
			glue_thr_q  <= GLUE_THR_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_SNODE_MIN: snode_min_q <= cfg_wdata[WGT_W-1:0];
				REG_GLUE_THR:  glue_thr_q  <= cfg_wdata[THR_W-1:0];
				default:       glue_thr_q  <= glue_thr_q;
			endcase
		end
	end

	// Entry fires unless it needs the result register and that is blocked
	assign pop    = head_valid && (!head.last || !out_valid_q || out_ready);
	assign decide = pop && head.last;

	// Neighbor already in the current class
	assign nid_in_range = (32'(head.nid) < MAX_VERTICES);
	assign vid_in_range = (32'(head.vid) < MAX_VERTICES);
	assign hit = head.present && nid_in_range && head.mem.assigned &&
		(head.mem.cls == cur_class_q);
	assign hits_eff = (hit && (hits_q != CNT_MAX)) ? hits_q + 1'b1 : hits_q;

	// Decision: hits * 1.0 >= threshold * size
	assign snode   = (head.weight >= snode_min_q);
	assign cls_inc = (cur_class_q != CLASS_MAX) ? cur_class_q + 1'b1 : cur_class_q;
	assign lhs     = {1'b0, hits_eff, 16'b0};
	assign rhs     = {13'b0, glue_thr_q} * {17'b0, cur_size_q};

	always_comb begin
		if (!first_q) begin
			glue = 1'b0;
			cls  = '0;
		end else if (snode && cur_super_q) begin
			glue = 1'b0;
			cls  = cls_inc;
		end else begin
			glue = (lhs >= rhs);
			cls  = glue ? cur_class_q : cls_inc;
		end
		super_after = glue ? (cur_super_q || snode) : snode;
	end

	// Membership store update
	assign place_wr.en   = decide && vid_in_range;
	assign place_wr.addr = head.vid;
	assign place_wr.cls  = cls;

	// Class state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_class_q <= '0;
			cur_size_q  <= '0;
			cur_super_q <= 1'b0;
			hits_q      <= '0;
			first_q     <= 1'b0;
		end else if (decide) begin
			hits_q      <= '0;
			first_q     <= 1'b1;
			cur_super_q <= super_after;
			if (glue) begin
				if (cur_size_q != CNT_MAX) begin
					cur_size_q <= cur_size_q + 1'b1;
				end
			end else begin
				cur_class_q <= cls;
				cur_size_q  <= CNT_W'(1);
			end
		end else if (pop) begin
			hits_q <= hits_eff;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (decide) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (decide) begin
			placed_q <= head.vid;
			class_q  <= cls;
			opened_q <= !glue;
			super_q  <= super_after;
		end
	end

	assign out_valid           = out_valid_q;
	assign placed_vertex       = placed_q;
	assign class_id            = class_q;
	assign opened_class        = opened_q;
	assign class_has_supernode = super_q;

endmodule

// ----- rtl/gsgc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsgc_checker
// Port-level checks on the class sequence reported by the block.
// ----------------------------------------------------------------------------
module gsgc_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [gsgc_pkg::VID_W-1:0]  placed_vertex,
	input  logic [gsgc_pkg::CLS_W-1:0]  class_id,
	input  logic                        opened_class
);

	import gsgc_pkg::*;

	logic             out_acc;
	logic             seen_q;
	logic [CLS_W-1:0] prev_cls_q;

	assign out_acc = out_valid && out_ready;

	// Class of the last delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 1'b0;
			prev_cls_q <= '0;
		end else if (out_acc) begin
			seen_q     <= 1'b1;
			prev_cls_q <= class_id;
		end
	end

	// A held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(class_id) &&
		$stable(placed_vertex))
		else $error("result changed while stalled");

	// The first result opens class zero
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !seen_q |-> opened_class && (class_id == '0))
		else $error("first result did not open class zero");

	// A joining vertex stays in the previous class
	a_join: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && seen_q && !opened_class |-> class_id == prev_cls_q)
		else $error("joined vertex changed class");

	// A new class is the next one, saturating at the top
	a_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && seen_q && opened_class |->
		(class_id == prev_cls_q + 1'b1) ||
		((prev_cls_q == CLASS_MAX) && (class_id == CLASS_MAX)))
		else $error("opened class is not the next one");

endmodule

bind greedy_sequential_graph_clustering_top gsgc_checker u_gsgc_checker (.*);

// ----- verif/tb_greedy_sequential_graph_clustering_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_greedy_sequential_graph_clustering_top
// Self-checking bench for the greedy graph clustering block. Neighbor-entry
// requests go in from a queue under random idling on both channels. A
// behavioral copy of the clustering state predicts every placement, and
// each placement taken from the block is checked field by field in order.
// Directed entries and random vertex runs under several register settings
// are used.
// ----------------------------------------------------------------------------
module tb_greedy_sequential_graph_clustering_top;
	import gsgc_pkg::*;

	// Quiet cycles tolerated; covers the store sweep after reset
	localparam int QUIET_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_PER_PHASE = 312;

	typedef struct packed {
		logic [VID_W-1:0] vid;
		logic [WGT_W-1:0] weight;
		logic [VID_W-1:0] nid;
		logic             present;
		logic             last;
	} entry_req_t;

	typedef struct packed {
		logic [VID_W-1:0] vid;
		logic [CLS_W-1:0] cls;
		logic             opened;
		logic             snode;
	} placement_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	cfg_reg_t         cfg_index = REG_SNODE_MIN;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [VID_W-1:0] vertex_id = '0;
	logic [WGT_W-1:0] vertex_weight = '0;
	logic [VID_W-1:0] neighbor_id = '0;
	logic             neighbor_present = 1'b0;
	logic             last_entry = 1'b0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [VID_W-1:0] placed_vertex;
	logic [CLS_W-1:0] class_id;
	logic             opened_class;
	logic             class_has_supernode;

	entry_req_t       entry_q [$];
	placement_t       expected_placements [$];
	logic [VID_W-1:0] recent_vid [$];

	logic req_taken = 1'b0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   quiet_cycles = 0;
	int   error_count = 0;
	bit   timed_out = 1'b0;

	// Shadow of the clustering state and registers
	logic [WGT_W-1:0] snode_min = SNODE_MIN_RST;
	logic [THR_W-1:0] glue_thr = GLUE_THR_RST;
	bit               placed_flag [MAX_VERTICES];
	bit   [CLS_W-1:0] placed_class [MAX_VERTICES];
	logic [CLS_W-1:0] cur_class = '0;
	logic [CNT_W-1:0] cur_size = '0;
	logic             cur_snode = 1'b0;
	logic [CNT_W-1:0] hit_count = '0;
	logic             first_done = 1'b0;

	greedy_sequential_graph_clustering_top dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_wdata           (cfg_wdata),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.vertex_id           (vertex_id),
		.vertex_weight       (vertex_weight),
		.neighbor_id         (neighbor_id),
		.neighbor_present    (neighbor_present),
		.last_entry          (last_entry),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.placed_vertex       (placed_vertex),
		.class_id            (class_id),
		.opened_class        (opened_class),
		.class_has_supernode (class_has_supernode)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic flag_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	// Count hits per entry; decide and record the placement on the last one
	task automatic predict_placement(input entry_req_t e);
		logic             snode;
		logic             glue;
		logic [CLS_W-1:0] cls;
		logic [CLS_W-1:0] next_cls;
		logic [31:0]      lhs;
		logic [31:0]      rhs;
		placement_t       p;
		if (e.present && placed_flag[e.nid] && placed_class[e.nid] == cur_class &&
			hit_count != CNT_MAX)
			hit_count++;
		if (!e.last)
			return;
		snode    = (e.weight >= snode_min);
		next_cls = (cur_class == CLASS_MAX) ? CLASS_MAX : cur_class + 1'b1;
		lhs      = 32'(hit_count) << 16;
		rhs      = 32'(glue_thr) * 32'(cur_size);
		if (!first_done) begin
			glue = 1'b0;
			cls  = '0;
		end else if (snode && cur_snode) begin
			glue = 1'b0;
			cls  = next_cls;
		end else begin
			glue = (lhs >= rhs);
			cls  = glue ? cur_class : next_cls;
		end
		if (glue) begin
			if (cur_size != CNT_MAX)
				cur_size++;
			if (snode)
				cur_snode = 1'b1;
		end else begin
			cur_class = cls;
			cur_size  = 1;
			cur_snode = snode;
		end
		first_done          = 1'b1;
		placed_flag[e.vid]  = 1'b1;
		placed_class[e.vid] = cls;
		hit_count           = '0;
		p.vid    = e.vid;
		p.cls    = cls;
		p.opened = !glue;
		p.snode  = cur_snode;
		expected_placements.push_back(p);
	endtask

	// Request driver: one entry from the queue, held until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (req_taken)
				void'(entry_q.pop_front());
			if (!in_valid || req_taken) begin
				if (entry_q.size() > (req_taken ? 0 : 0) && entry_q.size() != 0 &&
					$urandom_range(99) >= send_idle_pct) begin
					in_valid         <= 1'b1;
					vertex_id        <= entry_q[0].vid;
					vertex_weight    <= entry_q[0].weight;
					neighbor_id      <= entry_q[0].nid;
					neighbor_present <= entry_q[0].present;
					last_entry       <= entry_q[0].last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result side back-pressure
	always @(negedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Monitor: check placements, predict from accepted requests
	always @(posedge clk) begin
		placement_t exp_p;
		entry_req_t e;
		if (!arst_n) begin
			req_taken    <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			req_taken <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				if (expected_placements.size() == 0) begin
					flag_error($sformatf("unexpected placement of vertex %0d", placed_vertex));
				end else begin
					exp_p = expected_placements.pop_front();
					if (placed_vertex !== exp_p.vid)
						flag_error($sformatf("placed_vertex got %0d exp %0d",
							placed_vertex, exp_p.vid));
					if (class_id !== exp_p.cls)
						flag_error($sformatf("vertex %0d class_id got %0d exp %0d",
							exp_p.vid, class_id, exp_p.cls));
					if (opened_class !== exp_p.opened)
						flag_error($sformatf("vertex %0d opened_class got %0b exp %0b",
							exp_p.vid, opened_class, exp_p.opened));
					if (class_has_supernode !== exp_p.snode)
						flag_error($sformatf("vertex %0d class_has_supernode got %0b exp %0b",
							exp_p.vid, class_has_supernode, exp_p.snode));
				end
			end
			if (in_valid && in_ready) begin
				e.vid     = vertex_id;
				e.weight  = vertex_weight;
				e.nid     = neighbor_id;
				e.present = neighbor_present;
				e.last    = last_entry;
				predict_placement(e);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SNODE_MIN: snode_min = val[WGT_W-1:0];
			REG_GLUE_THR:  glue_thr  = val[THR_W-1:0];
			default:       ;
		endcase
	endtask

	task automatic queue_entry(input logic [VID_W-1:0] vid, input logic [WGT_W-1:0] weight,
		input logic [VID_W-1:0] nid, input logic present, input logic last);
		entry_req_t e;
		e.vid     = vid;
		e.weight  = weight;
		e.nid     = nid;
		e.present = present;
		e.last    = last;
		entry_q.push_back(e);
	endtask

	// Block is idle: queue empty, nothing outstanding, pipeline flushed
	task automatic wait_drained();
		while (entry_q.size() != 0 || in_valid || expected_placements.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Weights cluster around the supernode threshold
	function automatic logic [WGT_W-1:0] pick_weight();
		case ($urandom_range(3))
			0:       return snode_min - 1'b1;
			1:       return snode_min;
			2:       return snode_min + 1'b1;
			default: return WGT_W'($urandom);
		endcase
	endfunction

	// Neighbors mostly among recently placed vertices so hits are frequent
	function automatic logic [VID_W-1:0] pick_neighbor();
		int r;
		r = $urandom_range(9);
		if (r < 6 && recent_vid.size() != 0)
			return recent_vid[$urandom_range(recent_vid.size() - 1)];
		else if (r < 8)
			return VID_W'($urandom_range(63));
		else
			return VID_W'($urandom);
	endfunction

	// Random vertex runs with stray entries and mismatched mid-run fields
	task automatic queue_random_vertices(input int count);
		int               sent;
		int               k;
		int               j;
		logic [VID_W-1:0] vid;
		logic [WGT_W-1:0] weight;
		logic [VID_W-1:0] nid;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(9) == 0) begin
				queue_entry(VID_W'($urandom), WGT_W'($urandom), VID_W'($urandom),
					1'($urandom_range(1)), 1'b0);
				sent++;
			end else begin
				vid    = ($urandom_range(9) < 6) ? VID_W'($urandom_range(63)) : VID_W'($urandom);
				weight = pick_weight();
				if ($urandom_range(4) == 0)
					k = 0;
				else if ($urandom_range(19) == 0)
					k = $urandom_range(24, 7);
				else
					k = $urandom_range(6, 1);
				if (k == 0) begin
					queue_entry(vid, weight, VID_W'($urandom), 1'b0, 1'b1);
					sent++;
				end
				for (j = 0; j < k; j++) begin
					nid = pick_neighbor();
					if (j == k - 1)
						queue_entry(vid, weight, nid, $urandom_range(9) != 0, 1'b1);
					else if ($urandom_range(4) == 0)
						queue_entry(VID_W'($urandom), WGT_W'($urandom), nid,
							$urandom_range(9) != 0, 1'b0);
					else
						queue_entry(vid, weight, nid, $urandom_range(9) != 0, 1'b0);
					sent++;
				end
				recent_vid.push_back(vid);
				if (recent_vid.size() > 16)
					void'(recent_vid.pop_front());
			end
		end
	endtask

	task automatic run_stimulus();
		int p;
		// Registers written during the store sweep after reset
		write_reg(REG_SNODE_MIN, CFG_W'(SNODE_MIN_RST));
		write_reg(REG_GLUE_THR, CFG_W'(GLUE_THR_RST));

		// Directed: first vertex, supernode refusal, pads, equality, re-placement
		queue_entry(0, 0, 0, 1'b0, 1'b1);
		queue_entry(1, 16'hFFFF, 0, 1'b1, 1'b1);
		queue_entry(2, 5, 0, 1'b1, 1'b0);
		queue_entry(2, 5, 1, 1'b1, 1'b1);
		queue_entry(123, 16'hFFFF, 12'hFFF, 1'b1, 1'b0);
		queue_entry(77, 0, 2, 1'b1, 1'b0);
		queue_entry(77, 0, 2, 1'b0, 1'b0);
		queue_entry(12'hFFF, 4, 2, 1'b1, 1'b1);
		queue_entry(0, 3, 0, 1'b0, 1'b1);
		queue_entry(3, 4, 0, 1'b1, 1'b1);
		queue_entry(5, 4, 1, 1'b1, 1'b0);
		queue_entry(5, 4, 3, 1'b1, 1'b1);
		queue_entry(6, 4, 0, 1'b1, 1'b1);
		queue_entry(7, 4, 6, 1'b1, 1'b0);
		queue_entry(7, 4, 6, 1'b1, 1'b1);
		queue_entry(8, 5, 12'hFFF, 1'b1, 1'b0);
		queue_entry(8, 5, 7, 1'b1, 1'b1);
		queue_entry(9, 16'hFFFF, 7, 1'b1, 1'b1);
		queue_entry(10, 0, 12'hFFF, 1'b0, 1'b1);
		wait_drained();

		// Random phases, one idling pattern and register setting each
		for (p = 0; p < 4; p++) begin
			case (p)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
					write_reg(REG_SNODE_MIN, CFG_W'(12));
					write_reg(REG_GLUE_THR, CFG_W'(32768));
				end
				1: begin
					send_idle_pct  = 78;
					recv_stall_pct = 0;
					write_reg(REG_SNODE_MIN, CFG_W'(0));
					write_reg(REG_GLUE_THR, CFG_W'(0));
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 78;
					write_reg(REG_SNODE_MIN, CFG_W'(16'hFFFF));
					write_reg(REG_GLUE_THR, 17'h10000);
				end
				default: begin
					send_idle_pct  = 37;
					recv_stall_pct = 37;
					write_reg(REG_SNODE_MIN, CFG_W'($urandom_range(40)));
					write_reg(REG_GLUE_THR, CFG_W'($urandom_range(65536)));
				end
			endcase
			queue_random_vertices(RANDOM_PER_PHASE);
			wait_drained();
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		fork
			run_stimulus();
			begin
				while (quiet_cycles < QUIET_LIMIT)
					@(posedge clk);
				timed_out = 1'b1;
			end
		join_any
		if (!timed_out && error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
